// File: sv/ctok_pkg.sv
// Shared constants, types and lookup functions of the C subset tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package ctok_pkg;

   localparam int OFFSET_WIDTH_DEF = 32;
   localparam int LENGTH_WIDTH_DEF = 16;
   localparam int QUEUE_DEPTH      = 4;
   localparam int KIND_WIDTH       = 6;
   localparam int VALUE_WIDTH      = 64;

   localparam logic [5:0] KIND_PU_BASE = 6'd19;
   localparam logic [5:0] KIND_IDENT   = 6'd60;
   localparam logic [5:0] KIND_LIT     = 6'd61;
   localparam logic [5:0] KIND_END     = 6'd62;
   localparam logic [5:0] KIND_ERR     = 6'd63;

   typedef struct packed {
      logic       hit;
      logic       longer;
      logic [5:0] kind;
   } punct_type;

   function automatic logic is_letter(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b == " " || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic punct_type pu_one(input logic [7:0] b);
      punct_type r;
      r = '{hit: 1'b1, longer: 1'b0, kind: KIND_ERR};
      case (b)
         ",": r.kind = KIND_PU_BASE + 6'd0;
         "?": r.kind = KIND_PU_BASE + 6'd1;
         ":": r.kind = KIND_PU_BASE + 6'd2;
         ";": r.kind = KIND_PU_BASE + 6'd3;
         "(": r.kind = KIND_PU_BASE + 6'd4;
         ")": r.kind = KIND_PU_BASE + 6'd5;
         "{": r.kind = KIND_PU_BASE + 6'd6;
         "}": r.kind = KIND_PU_BASE + 6'd7;
         "~": r.kind = KIND_PU_BASE + 6'd8;
         "+": begin r.kind = KIND_PU_BASE + 6'd16; r.longer = 1'b1; end
         "-": begin r.kind = KIND_PU_BASE + 6'd17; r.longer = 1'b1; end
         "*": begin r.kind = KIND_PU_BASE + 6'd18; r.longer = 1'b1; end
         "/": begin r.kind = KIND_PU_BASE + 6'd19; r.longer = 1'b1; end
         "%": begin r.kind = KIND_PU_BASE + 6'd20; r.longer = 1'b1; end
         "&": begin r.kind = KIND_PU_BASE + 6'd28; r.longer = 1'b1; end
         "|": begin r.kind = KIND_PU_BASE + 6'd29; r.longer = 1'b1; end
         "^": begin r.kind = KIND_PU_BASE + 6'd30; r.longer = 1'b1; end
         "!": begin r.kind = KIND_PU_BASE + 6'd34; r.longer = 1'b1; end
         "=": begin r.kind = KIND_PU_BASE + 6'd38; r.longer = 1'b1; end
         ">": begin r.kind = KIND_PU_BASE + 6'd39; r.longer = 1'b1; end
         "<": begin r.kind = KIND_PU_BASE + 6'd40; r.longer = 1'b1; end
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

   function automatic punct_type pu_two(input logic [15:0] s);
      punct_type r;
      r = '{hit: 1'b1, longer: 1'b0, kind: KIND_ERR};
      case (s)
         "++": r.kind = KIND_PU_BASE + 6'd9;
         "--": r.kind = KIND_PU_BASE + 6'd10;
         "+=": r.kind = KIND_PU_BASE + 6'd11;
         "-=": r.kind = KIND_PU_BASE + 6'd12;
         "*=": r.kind = KIND_PU_BASE + 6'd13;
         "/=": r.kind = KIND_PU_BASE + 6'd14;
         "%=": r.kind = KIND_PU_BASE + 6'd15;
         "&&": r.kind = KIND_PU_BASE + 6'd21;
         "||": r.kind = KIND_PU_BASE + 6'd22;
         "&=": r.kind = KIND_PU_BASE + 6'd23;
         "|=": r.kind = KIND_PU_BASE + 6'd24;
         "^=": r.kind = KIND_PU_BASE + 6'd25;
         ">>": begin r.kind = KIND_PU_BASE + 6'd31; r.longer = 1'b1; end
         "<<": begin r.kind = KIND_PU_BASE + 6'd32; r.longer = 1'b1; end
         "!=": r.kind = KIND_PU_BASE + 6'd33;
         "==": r.kind = KIND_PU_BASE + 6'd35;
         ">=": r.kind = KIND_PU_BASE + 6'd36;
         "<=": r.kind = KIND_PU_BASE + 6'd37;
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

   function automatic punct_type pu_three(input logic [23:0] s);
      punct_type r;
      r = '{hit: 1'b1, longer: 1'b0, kind: KIND_ERR};
      case (s)
         ">>=": r.kind = KIND_PU_BASE + 6'd26;
         "<<=": r.kind = KIND_PU_BASE + 6'd27;
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

   // word holds its bytes with the first byte highest
   function automatic logic [5:0] kw_kind(input logic [63:0] w);
      logic [5:0] k;
      k = KIND_IDENT;
      case (w)
         64'("return"):   k = 6'd0;
         64'("void"):     k = 6'd1;
         64'("if"):       k = 6'd2;
         64'("else"):     k = 6'd3;
         64'("do"):       k = 6'd4;
         64'("while"):    k = 6'd5;
         64'("for"):      k = 6'd6;
         64'("goto"):     k = 6'd7;
         64'("break"):    k = 6'd8;
         64'("continue"): k = 6'd9;
         64'("static"):   k = 6'd10;
         64'("extern"):   k = 6'd11;
         64'("switch"):   k = 6'd12;
         64'("case"):     k = 6'd13;
         64'("default"):  k = 6'd14;
         64'("int"):      k = 6'd15;
         64'("unsigned"): k = 6'd16;
         64'("signed"):   k = 6'd17;
         64'("long"):     k = 6'd18;
         default:         k = KIND_IDENT;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

// File: sv/ctok_front.sv
// Front part: scans bytes and builds up to two result records per byte.
`timescale 1ns / 1ps
`default_nettype none
module ctok_front
   import ctok_pkg::*;
#(
   parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
   parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF,
   parameter int REC_W = KIND_WIDTH + VALUE_WIDTH + OFFSET_WIDTH + LENGTH_WIDTH + 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_take,
   input  wire logic [7:0]             in_byte,
   output logic                        push,
   output logic [2*REC_W:0]            push_data
);

   typedef struct packed {
      logic                    last;
      logic [LENGTH_WIDTH-1:0] length;
      logic [OFFSET_WIDTH-1:0] start;
      logic [VALUE_WIDTH-1:0]  value;
      logic [KIND_WIDTH-1:0]   kind;
   } rec_type;

   typedef enum logic [2:0] {
      M_IDLE, M_WORD, M_NUM, M_PUNCT, M_DISCARD
   } mode_type;

   localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;
   localparam logic [LENGTH_WIDTH-1:0] LEN_ONE = LENGTH_WIDTH'(1);
   localparam logic [LENGTH_WIDTH-1:0] LEN_TWO = LENGTH_WIDTH'(2);
   localparam logic [LENGTH_WIDTH-1:0] LEN_THREE = LENGTH_WIDTH'(3);
   localparam logic [LENGTH_WIDTH-1:0] LEN_EIGHT = LENGTH_WIDTH'(8);

   mode_type                mode_ff, mode_in;
   logic [15:0]             pend_ff, pend_in;
   logic [63:0]             word_ff, word_in;
   logic [LENGTH_WIDTH-1:0] run_ff, run_in;
   logic [63:0]             acc_ff, acc_in;
   logic [OFFSET_WIDTH-1:0] pos_ff, pos_in;
   logic [OFFSET_WIDTH-1:0] tstart_ff, tstart_in;

   rec_type   close_rec, idle_rec;
   logic      close_v, idle_v, used;
   punct_type p1, p2, p3, pc1, pc2;
   logic [LENGTH_WIDTH-1:0] run_inc;
   logic [63:0] digit;

   always_comb begin
      run_inc = (run_ff < LEN_MAX) ? run_ff + LEN_ONE : LEN_MAX;
      digit   = 64'(in_byte - "0");
      p1  = pu_one(in_byte);
      pc1 = pu_one(pend_ff[7:0]);
      p2  = pu_two({pend_ff[7:0], in_byte});
      pc2 = pu_two(pend_ff);
      p3  = pu_three({pend_ff, in_byte});

      mode_in   = mode_ff;
      pend_in   = pend_ff;
      word_in   = word_ff;
      run_in    = run_ff;
      acc_in    = acc_ff;
      tstart_in = tstart_ff;
      pos_in    = pos_ff + OFFSET_WIDTH'(1);
      used      = 1'b0;
      close_v   = 1'b0;
      idle_v    = 1'b0;
      close_rec = '{last: 1'b0, length: run_ff, start: tstart_ff, value: '0,
                    kind: KIND_IDENT};
      idle_rec  = '{last: 1'b0, length: LEN_ONE, start: pos_ff, value: '0,
                    kind: KIND_ERR};

      unique case (mode_ff)
         M_WORD: begin
            if (is_letter(in_byte) || is_digit(in_byte) || in_byte == "_") begin
               if (run_ff < LEN_EIGHT) word_in = {word_ff[55:0], in_byte};
               run_in = run_inc;
               used   = 1'b1;
            end else begin
               close_v = 1'b1;
               close_rec.kind = (run_ff <= LEN_EIGHT) ? kw_kind(word_ff) : KIND_IDENT;
               mode_in = M_IDLE;
            end
         end
         M_NUM: begin
            if (is_digit(in_byte)) begin
               acc_in = {acc_ff[60:0], 3'b0} + {acc_ff[62:0], 1'b0} + digit;
               run_in = run_inc;
               used   = 1'b1;
            end else begin
               close_v = 1'b1;
               close_rec.kind  = KIND_LIT;
               close_rec.value = acc_ff;
               mode_in = M_IDLE;
            end
         end
         M_PUNCT: begin
            if (run_ff == LEN_TWO) begin
               close_v = 1'b1;
               used    = p3.hit;
               close_rec.kind   = p3.hit ? p3.kind : (pc2.hit ? pc2.kind : KIND_ERR);
               close_rec.length = p3.hit ? LEN_THREE : LEN_TWO;
               mode_in = M_IDLE;
            end else if (p2.hit) begin
               used = 1'b1;
               if (p2.longer) begin
                  pend_in = {pend_ff[7:0], in_byte};
                  run_in  = LEN_TWO;
               end else begin
                  close_v = 1'b1;
                  close_rec.kind   = p2.kind;
                  close_rec.length = LEN_TWO;
                  mode_in = M_IDLE;
               end
            end else begin
               close_v = 1'b1;
               close_rec.kind   = pc1.hit ? pc1.kind : KIND_ERR;
               close_rec.length = LEN_ONE;
               mode_in = M_IDLE;
            end
            // a three-byte match is emitted as the closing record
         end
         M_DISCARD: begin
            used = 1'b1;
            if (in_byte == 8'd0) begin
               mode_in = M_IDLE;
               pos_in  = '0;
            end
         end
         M_IDLE: ;
         default: mode_in = M_IDLE;
      endcase

      if (!used) begin
         if (in_byte == 8'd0) begin
            idle_v = 1'b1;
            idle_rec.kind   = KIND_END;
            idle_rec.length = '0;
            idle_rec.last   = 1'b1;
            mode_in = M_IDLE;
            pos_in  = '0;
         end else if (is_space(in_byte)) begin
            mode_in = M_IDLE;
         end else if (is_letter(in_byte)) begin
            mode_in   = M_WORD;
            tstart_in = pos_ff;
            word_in   = {56'd0, in_byte};
            run_in    = LEN_ONE;
         end else if (is_digit(in_byte)) begin
            mode_in   = M_NUM;
            tstart_in = pos_ff;
            acc_in    = digit;
            run_in    = LEN_ONE;
         end else if (p1.hit && p1.longer) begin
            mode_in   = M_PUNCT;
            tstart_in = pos_ff;
            pend_in   = {8'd0, in_byte};
            run_in    = LEN_ONE;
         end else if (p1.hit) begin
            idle_v = 1'b1;
            idle_rec.kind = p1.kind;
            mode_in = M_IDLE;
         end else begin
            idle_v = 1'b1;
            idle_rec.length = '0;
            idle_rec.last   = 1'b1;
            mode_in = M_DISCARD;
         end
      end

      push = in_take && (close_v || idle_v);
      if (close_v) begin
         push_data = {idle_v, idle_rec, close_rec};
      end else begin
         push_data = {1'b0, idle_rec, idle_rec};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         pend_ff   <= '0;
         word_ff   <= '0;
         run_ff    <= '0;
         acc_ff    <= '0;
         pos_ff    <= '0;
         tstart_ff <= '0;
      end else if (in_take) begin
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
         word_ff   <= word_in;
         run_ff    <= run_in;
         acc_ff    <= acc_in;
         pos_ff    <= pos_in;
         tstart_ff <= tstart_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/ctok_queue.sv
// Short queue of record pairs between the scanner and the output stage.
`timescale 1ns / 1ps
`default_nettype none
module ctok_queue
   import ctok_pkg::*;
#(
   parameter int W = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic [W-1:0] push_data,
   output logic              full,
   output logic              nonempty,
   input  wire logic         pop,
   output logic [W-1:0]      pop_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [W-1:0]  mem [QUEUE_DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] cnt_ff;

   assign full     = cnt_ff == CW'(QUEUE_DEPTH);
   assign nonempty = cnt_ff != '0;
   assign pop_data = mem[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + AW'(1);
         if (pop)  rd_ff <= (rd_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + AW'(1);
         cnt_ff <= cnt_ff + CW'(push) - CW'(pop);
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> nonempty) else $error("queue underflow");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(QUEUE_DEPTH)) else $error("queue count out of range");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> nonempty) else $error("queue lost a word");
`endif

endmodule
`default_nettype wire

// File: sv/ctok_out.sv
// Back part: splits record pairs and drives the registered result channel.
`timescale 1ns / 1ps
`default_nettype none
module ctok_out
   import ctok_pkg::*;
#(
   parameter int REC_W = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_nonempty,
   input  wire logic [2*REC_W:0] q_data,
   output logic                  q_pop,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [REC_W-1:0]      out_rec
);

   logic [REC_W-1:0] out_ff, hold_ff;
   logic             out_v_ff, hold_v_ff;
   logic             slot_free;

   assign slot_free = !out_v_ff || out_ready;
   assign q_pop     = slot_free && !hold_v_ff && q_nonempty;
   assign out_valid = out_v_ff;
   assign out_rec   = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         hold_v_ff <= 1'b0;
      end else if (slot_free) begin
         if (hold_v_ff) begin
            out_v_ff  <= 1'b1;
            hold_v_ff <= 1'b0;
         end else begin
            out_v_ff  <= q_nonempty;
            hold_v_ff <= q_nonempty && q_data[2*REC_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free) begin
         if (hold_v_ff) begin
            out_ff <= hold_ff;
         end else begin
            out_ff  <= q_data[REC_W-1:0];
            hold_ff <= q_data[2*REC_W-1:REC_W];
         end
      end
   end

endmodule
`default_nettype wire

// File: sv/c_subset_tokenizer.sv
// Top level of the C subset tokenizer: scanner, record queue and output stage.
//
//  channel | dir | word                                   | accepted when
//  req_    | in  | one source byte, 0 ends the text       | req_tvalid & req_tready
//  rsp_    | out | one token record, tlast on end/error   | rsp_tvalid & rsp_tready
//
// One byte per cycle while the queue has room; a byte that yields two records
// has them sent one at a time through the single result register.
// A result is written into the queue when its closing byte is taken, then into the result register.
// Synchronous reset returns the scanner to idle at offset zero and empties the queue.
// A stalled result side fills the four-entry queue, then drops req_tready.
`timescale 1ns / 1ps
`default_nettype none
module c_subset_tokenizer
   import ctok_pkg::*;
#(
   parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
   parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEF,
   localparam int REC_W  = KIND_WIDTH + VALUE_WIDTH + OFFSET_WIDTH + LENGTH_WIDTH + 1,
   localparam int DATA_W = ((REC_W - 1 + 7) / 8) * 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,   // text_byte
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata,   // token_kind, literal_value, start_offset, token_length
   output logic                   rsp_tlast
);

   logic               take, push, full, nonempty, pop;
   logic [2*REC_W:0]   push_data, pop_data;
   logic [REC_W-1:0]   rec;

   assign req_tready = !full;
   assign take       = req_tvalid && req_tready;

   ctok_front #(
      .OFFSET_WIDTH(OFFSET_WIDTH),
      .LENGTH_WIDTH(LENGTH_WIDTH),
      .REC_W       (REC_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_take  (take),
      .in_byte  (req_tdata),
      .push     (push),
      .push_data(push_data)
   );

   ctok_queue #(
      .W(2 * REC_W + 1)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .full     (full),
      .nonempty (nonempty),
      .pop      (pop),
      .pop_data (pop_data)
   );

   ctok_out #(
      .REC_W(REC_W)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .q_nonempty(nonempty),
      .q_data    (pop_data),
      .q_pop     (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (rec)
   );

   assign rsp_tdata = DATA_W'(rec[REC_W-2:0]);
   assign rsp_tlast = rec[REC_W-1];

endmodule
`default_nettype wire

// File: test/c_subset_tokenizer_check.sv
// Checker of the C subset tokenizer: predicts token records from accepted bytes and compares.
`timescale 1ns / 1ps
module c_subset_tokenizer_check
   import ctok_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [7:0]   req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [119:0] rsp_tdata,
   input  wire logic         rsp_tlast,
   output int                fail_count,
   output int                pending_count
);
   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_WORD, SCAN_NUM, SCAN_PUNCT, SCAN_DISCARD
   } scan_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [63:0] value;
      logic [31:0] start;
      logic [15:0] len;
      logic        last;
   } token_type;

   token_type   tokens_due[$];
   scan_type    mode;
   logic [15:0] held_punct;
   logic [63:0] word_bytes;
   logic [15:0] run_len;
   logic [63:0] acc;
   logic [31:0] pos;
   logic [31:0] tok_start;

   function automatic token_type mk(logic [5:0] k, logic [63:0] v, logic [31:0] s,
                                    logic [15:0] l, logic t);
      token_type r;
      r.kind = k; r.value = v; r.start = s; r.len = l; r.last = t;
      return r;
   endfunction

   function automatic logic letter(logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
   endfunction

   function automatic logic digit(logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   // kind of a punctuator of 1..3 chars, first char lowest; longer says a longer match exists
   function automatic logic [5:0] punct_kind(logic [23:0] s, int n, output logic longer);
      string p1;
      logic [5:0] k;
      p1 = ",?:;(){}~";
      k = KIND_ERR;
      longer = 1'b0;
      if (n == 1) begin
         for (int i = 0; i < 9; i++) if (s[7:0] == p1[i]) k = 6'd19 + 6'(i);
         case (s[7:0])
            "+": k = 6'd35; "-": k = 6'd36; "*": k = 6'd37; "/": k = 6'd38;
            "%": k = 6'd39; "&": k = 6'd47; "|": k = 6'd48; "^": k = 6'd49;
            "!": k = 6'd53; "=": k = 6'd57; ">": k = 6'd58; "<": k = 6'd59;
            default: ;
         endcase
         longer = (k >= 6'd35 && k != KIND_ERR);
      end else if (n == 2) begin
         case ({s[7:0], s[15:8]})
            "++": k = 6'd28; "--": k = 6'd29; "+=": k = 6'd30; "-=": k = 6'd31;
            "*=": k = 6'd32; "/=": k = 6'd33; "%=": k = 6'd34; "&&": k = 6'd40;
            "||": k = 6'd41; "&=": k = 6'd42; "|=": k = 6'd43; "^=": k = 6'd44;
            ">>": begin k = 6'd50; longer = 1'b1; end
            "<<": begin k = 6'd51; longer = 1'b1; end
            "!=": k = 6'd52; "==": k = 6'd54; ">=": k = 6'd55; "<=": k = 6'd56;
            default: ;
         endcase
      end else begin
         case ({s[7:0], s[15:8], s[23:16]})
            ">>=": k = 6'd45; "<<=": k = 6'd46;
            default: ;
         endcase
      end
      return k;
   endfunction

   function automatic logic [5:0] word_kind(logic [63:0] w, logic [15:0] n);
      string kws[19];
      logic  ok;
      kws = '{"return", "void", "if", "else", "do", "while", "for", "goto", "break",
              "continue", "static", "extern", "switch", "case", "default", "int",
              "unsigned", "signed", "long"};
      if (n > 8) return KIND_IDENT;
      for (int i = 0; i < 19; i++) begin
         if (kws[i].len() == n) begin
            ok = 1'b1;
            for (int j = 0; j < n; j++) if (w[8*j +: 8] != kws[i][j]) ok = 1'b0;
            if (ok) return 6'(i);
         end
      end
      return KIND_IDENT;
   endfunction

   task automatic scan_byte(logic [7:0] b);
      logic       used, lg;
      logic [5:0] k;
      logic [23:0] ext;
      int         n;
      used = 1'b0;
      if (mode == SCAN_DISCARD) begin
         if (b == 0) begin
            mode = SCAN_IDLE; pos = 0;
         end else pos = pos + 1;
         return;
      end
      case (mode)
         SCAN_WORD: begin
            if (letter(b) || digit(b) || b == "_") begin
               if (run_len < 8) word_bytes[8*run_len +: 8] = b;
               if (run_len != 16'hffff) run_len = run_len + 1;
               used = 1'b1;
            end else begin
               tokens_due.push_back(mk(word_kind(word_bytes, run_len), 0, tok_start,
                                       run_len, 0));
               mode = SCAN_IDLE;
            end
         end
         SCAN_NUM: begin
            if (digit(b)) begin
               acc = acc * 10 + 64'(b - 8'h30);
               if (run_len != 16'hffff) run_len = run_len + 1;
               used = 1'b1;
            end else begin
               tokens_due.push_back(mk(KIND_LIT, acc, tok_start, run_len, 0));
               mode = SCAN_IDLE;
            end
         end
         SCAN_PUNCT: begin
            n = (run_len == 2) ? 2 : 1;
            ext = {8'h00, held_punct};
            ext[8*n +: 8] = b;
            k = punct_kind(ext, n + 1, lg);
            if (k != KIND_ERR) begin
               used = 1'b1;
               if (lg) begin
                  held_punct = ext[15:0]; run_len = 16'(n + 1);
               end else begin
                  tokens_due.push_back(mk(k, 0, tok_start, 16'(n + 1), 0));
                  mode = SCAN_IDLE;
               end
            end else begin
               k = punct_kind({8'h00, held_punct}, n, lg);
               tokens_due.push_back(mk(k, 0, tok_start, 16'(n), 0));
               mode = SCAN_IDLE;
            end
         end
         default: mode = SCAN_IDLE;
      endcase
      if (!used) begin
         if (b == 0) begin
            tokens_due.push_back(mk(KIND_END, 0, pos, 0, 1));
            mode = SCAN_IDLE; pos = 0;
            return;
         end else if (b == " " || (b >= 9 && b <= 13)) begin
         end else if (letter(b)) begin
            mode = SCAN_WORD; tok_start = pos; word_bytes = 64'(b); run_len = 1;
         end else if (digit(b)) begin
            mode = SCAN_NUM; tok_start = pos; acc = 64'(b - 8'h30); run_len = 1;
         end else begin
            k = punct_kind({16'h0, b}, 1, lg);
            if (k == KIND_ERR) begin
               tokens_due.push_back(mk(KIND_ERR, 0, pos, 0, 1));
               mode = SCAN_DISCARD;
            end else if (lg) begin
               mode = SCAN_PUNCT; tok_start = pos; held_punct = {8'h00, b}; run_len = 1;
            end else tokens_due.push_back(mk(k, 0, pos, 1, 0));
         end
      end
      pos = pos + 1;
   endtask

   always @(posedge clock) begin
      token_type got, want;
      if (reset) begin
         mode = SCAN_IDLE; held_punct = 0; word_bytes = 0; run_len = 0;
         acc = 0; pos = 0; tok_start = 0;
         tokens_due.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[5:0], rsp_tdata[69:6], rsp_tdata[101:70],
                   rsp_tdata[117:102], rsp_tlast};
            if (tokens_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected token record, expected none, actual %h",
                        $time, got);
            end else begin
               want = tokens_due.pop_front();
               if (got !== want) begin
                  fail_count++;
                  $display({"%0t: token mismatch, expected kind %0d value %0d start %0d",
                            " len %0d last %b, actual kind %0d value %0d start %0d",
                            " len %0d last %b"},
                           $time, want.kind, want.value, want.start, want.len, want.last,
                           got.kind, got.value, got.start, got.len, got.last);
               end
            end
         end
         if (req_tvalid && req_tready) scan_byte(req_tdata);
      end
      pending_count = tokens_due.size();
   end
endmodule

// File: test/c_subset_tokenizer_test.sv
// Testbench top of the C subset tokenizer: drives source text and gives the verdict.
`timescale 1ns / 1ps
module c_subset_tokenizer_test;
   import ctok_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [119:0] rsp_tdata;
   logic         rsp_tlast;
   int           fail_count;
   int           pending_count;
   int           quiet_cycles;
   int           bytes_sent;
   logic         done;

   c_subset_tokenizer u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   c_subset_tokenizer_check u_check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // random receiver stall per word
   initial begin
      int gap;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         repeat (gap) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("c_subset_tokenizer test failed");
         $finish;
      end
   end

   // hold tvalid across back-to-back words; drop it only for a gap
   task automatic send_byte(logic [7:0] b, bit burst);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_text(string s, bit burst);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], burst);
   endtask

   function automatic string pick_token();
      string pool[36];
      string w;
      string pu;
      int    n;
      pool = '{"return", "void", "if", "else", "do", "while", "for", "goto", "break",
               "continue", "static", "extern", "switch", "case", "default", "int",
               "unsigned", "signed", "long", ">>=", "<<=", "++", "--", "&&", "||",
               "==", "!=", "<=", ">=", "->", "+=", "%", "~", "{", "}", ";"};
      pu = ",?:()*/^|&!=<>-+";
      case ($urandom_range(0, 4))
         0: return pool[$urandom_range(0, 35)];
         1: begin
            w = "";
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
               w = {w, string'(i == 0 ? 8'(8'h61 + $urandom_range(0, 25))
                   : ($urandom_range(0, 5) == 0 ? "_" : 8'(8'h41 + $urandom_range(0, 25))))};
            return w;
         end
         2: begin
            w = "";
            n = $urandom_range(1, 24);
            for (int i = 0; i < n; i++) w = {w, string'(8'(8'h30 + $urandom_range(0, 9)))};
            return w;
         end
         3: return {pool[$urandom_range(0, 18)], string'(8'(8'h30 + $urandom_range(0, 9)))};
         default: return string'(pu[$urandom_range(0, 15)]);
      endcase
   endfunction

   initial begin
      bit burst;
      logic [7:0] b;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= 8'h00;
      bytes_sent = 0;
      done = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_text("return continue x1_ 12ab >>=<<=>>>=<<<", 0);
      send_byte(8'h00, 0);
      send_text("\t\n\v\f\r 18446744073709551616+--&&!", 0);
      send_byte(8'h00, 0);
      send_text("abc _x 5", 0);
      send_byte(8'h00, 0);
      send_text("a", 0); send_byte(8'hff, 0); send_byte(8'h80, 0);
      send_byte(8'h00, 0);
      send_byte(8'h00, 0);
      stop_sending();

      while (pending_count != 0) @(posedge clock);

      while (bytes_sent < 1450) begin
         burst = ($urandom_range(0, 4) == 0);
         for (int t = 0; t < $urandom_range(1, 10); t++) begin
            send_text(pick_token(), burst);
            if ($urandom_range(0, 2) != 0) send_byte(" ", burst);
         end
         if ($urandom_range(0, 9) == 0) begin
            b = 8'($urandom_range(1, 255));
            send_byte(b, burst);
         end
         send_byte(8'h00, burst);
         if ($urandom_range(0, 20) == 0) begin
            b = 8'($urandom_range(0, 255));
            send_byte(b, burst);
         end
      end
      send_byte(8'h00, 0);
      stop_sending();

      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("c_subset_tokenizer test passed");
      else $display("c_subset_tokenizer test failed");
      $finish;
   end
endmodule
